@@ rtl/tlm_pkg.sv @@
// ============================================================================
// tlm_pkg: shared types and constants of the thermal level monitor
// Beat structs, job record between front and back, codes and reset values.
// ============================================================================
`timescale 1ns / 1ps

package tlm_pkg;

    // config port geometry
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WARN  = 3'd0,
        REG_CRIT  = 3'd1,
        REG_HYST  = 3'd2,
        REG_PANIC = 3'd3,
        REG_GRACE = 3'd4
    } t_reg_idx;

    // register reset values
    localparam logic signed [11:0] WARN_RST  = 12'sd700;
    localparam logic signed [11:0] CRIT_RST  = 12'sd850;
    localparam logic        [8:0]  HYST_RST  = 9'd30;
    localparam logic signed [11:0] PANIC_RST = 12'sd1000;
    localparam logic        [19:0] GRACE_RST = 20'd10000;

    // fixed panic hysteresis, 3.0 degrees
    localparam logic signed [12:0] PANIC_HYST = 13'sd30;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // level codes
    localparam logic [1:0] LVL_NORMAL = 2'd0;
    localparam logic [1:0] LVL_WARN   = 2'd1;
    localparam logic [1:0] LVL_CRIT   = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_UPDATE = 3'd0;
    localparam logic [2:0] KIND_WARN   = 3'd1;
    localparam logic [2:0] KIND_CRIT   = 3'd2;
    localparam logic [2:0] KIND_PANIC  = 3'd3;
    localparam logic [2:0] KIND_FAULT  = 3'd4;

    // input beat
    typedef struct packed {
        logic              cmd;
        logic signed [11:0] temp_tenths;
        logic              sample_valid;
    } t_cmd;

    // result beat
    typedef struct packed {
        logic [2:0]         event_kind;
        logic signed [11:0] event_temp;
        logic [1:0]         level;
        logic               panic_on;
        logic               sensor_ok;
        logic [31:0]        sample_count;
        logic               last;
    } t_res;

    // classified sample handed from front to back
    typedef struct packed {
        logic               fault;
        logic               lvl_evt;
        logic [1:0]         lvl_kind;
        logic               pnc_evt;
        logic signed [11:0] temp;
        logic [1:0]         level;
        logic               panic_on;
        logic               sensor_ok;
        logic [31:0]        count;
    } t_job;

    // back-end beat sequencer
    typedef enum logic [1:0] {
        BEAT_UPD,
        BEAT_LVL,
        BEAT_PNC
    } t_beat;

endpackage

@@ rtl/tlm_front.sv @@
// ============================================================================
// tlm_front: input side of the thermal level monitor
// Holds config and monitor state, takes ticks and samples, pushes one job
// per sample into the job queue.
// ============================================================================
`timescale 1ns / 1ps

module tlm_front
    import tlm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_cmd                 i_item,
    output logic                 o_full,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output logic                 o_job_push,
    output t_job                 o_job,
    input  logic                 i_job_full
);

    // config registers; grace length only reloads the countdown
    logic signed [11:0] r_warn, r_crit, r_panic;
    logic        [8:0]  r_hyst;

    // monitor state; health flag travels in each job
    logic [1:0]         r_level, n_level;
    logic               r_panic_on, n_panic_on;
    logic signed [11:0] r_last_temp;
    logic [31:0]        r_count, n_count;
    logic [19:0]        r_grace_left;

    logic               w_accept;
    logic               w_sample;
    logic               w_valid;
    logic signed [12:0] w_t;
    logic signed [12:0] w_warn_lo, w_crit_lo, w_panic_lo;
    logic               w_ge_warn, w_ge_crit, w_ge_panic;
    logic               w_pnc_evt;

    assign o_full   = i_job_full;
    assign w_accept = i_push && !i_job_full;
    assign w_sample = w_accept && (i_item.cmd == CMD_SAMPLE);
    assign w_valid  = i_item.sample_valid;

    // threshold compares, 13 bit signed so the lowered thresholds cannot wrap
    assign w_t        = {i_item.temp_tenths[11], i_item.temp_tenths};
    assign w_warn_lo  = {r_warn[11], r_warn} - $signed({4'b0, r_hyst});
    assign w_crit_lo  = {r_crit[11], r_crit} - $signed({4'b0, r_hyst});
    assign w_panic_lo = {r_panic[11], r_panic} - PANIC_HYST;
    assign w_ge_warn  = i_item.temp_tenths >= r_warn;
    assign w_ge_crit  = i_item.temp_tenths >= r_crit;
    assign w_ge_panic = i_item.temp_tenths >= r_panic;

    // level hysteresis
    always_comb begin
        n_level = r_level;
        unique case (r_level)
            LVL_NORMAL: begin
                if (w_ge_crit)      n_level = LVL_CRIT;
                else if (w_ge_warn) n_level = LVL_WARN;
            end
            LVL_WARN: begin
                if (w_ge_crit)              n_level = LVL_CRIT;
                else if (w_t < w_warn_lo)   n_level = LVL_NORMAL;
            end
            default: begin
                if (w_t < w_crit_lo) n_level = LVL_WARN;
            end
        endcase
    end

    // panic latch
    always_comb begin
        n_panic_on = r_panic_on;
        w_pnc_evt  = 1'b0;
        if (w_ge_panic && !r_panic_on) begin
            n_panic_on = 1'b1;
            w_pnc_evt  = 1'b1;
        end else if (r_panic_on && (w_t < w_panic_lo)) begin
            n_panic_on = 1'b0;
        end
    end

    assign n_count = r_count + 32'd1;

    // job record for the back end
    always_comb begin
        o_job_push = w_sample;
        o_job      = '0;
        if (w_valid) begin
            o_job.fault     = 1'b0;
            o_job.lvl_evt   = (n_level != r_level) && (r_grace_left == '0)
                              && (n_level != LVL_NORMAL);
            o_job.lvl_kind  = n_level;
            o_job.pnc_evt   = w_pnc_evt;
            o_job.temp      = i_item.temp_tenths;
            o_job.level     = n_level;
            o_job.panic_on  = n_panic_on;
            o_job.sensor_ok = 1'b1;
            o_job.count     = n_count;
        end else begin
            o_job.fault     = 1'b1;
            o_job.temp      = r_last_temp;
            o_job.level     = r_level;
            o_job.panic_on  = r_panic_on;
            o_job.sensor_ok = 1'b0;
            o_job.count     = r_count;
        end
    end

    // config and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn       <= WARN_RST;
            r_crit       <= CRIT_RST;
            r_hyst       <= HYST_RST;
            r_panic      <= PANIC_RST;
            r_level      <= LVL_NORMAL;
            r_panic_on   <= 1'b0;
            r_last_temp  <= '0;
            r_count      <= '0;
            r_grace_left <= GRACE_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WARN:  r_warn  <= i_cfg_wdata[11:0];
                    REG_CRIT:  r_crit  <= i_cfg_wdata[11:0];
                    REG_HYST:  r_hyst  <= i_cfg_wdata[8:0];
                    REG_PANIC: r_panic <= i_cfg_wdata[11:0];
                    REG_GRACE: begin
                        r_grace_left <= i_cfg_wdata[19:0];
                    end
                    default: ;
                endcase
            end
            if (w_accept && (i_item.cmd == CMD_TICK) && (r_grace_left != '0)
                && !(i_cfg_we && (i_cfg_idx == REG_GRACE))) begin
                r_grace_left <= r_grace_left - 20'd1;
            end
            if (w_sample && w_valid) begin
                r_level     <= n_level;
                r_panic_on  <= n_panic_on;
                r_last_temp <= i_item.temp_tenths;
                r_count     <= n_count;
            end
        end
    end

endmodule

@@ rtl/tlm_queue.sv @@
// ============================================================================
// tlm_queue: job queue between front and back
// Small circular buffer of classified samples; head is shown while valid.
// ============================================================================
`timescale 1ns / 1ps

module tlm_queue
    import tlm_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/tlm_back.sv @@
// ============================================================================
// tlm_back: result side of the thermal level monitor
// Expands each job into one to three result beats into an output register.
// ============================================================================
`timescale 1ns / 1ps

module tlm_back
    import tlm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_pop,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);

    t_beat r_beat, n_beat;
    t_res  r_res, w_res;
    logic  r_out_valid;
    logic  w_load;

    assign o_empty = !r_out_valid;
    assign o_res   = r_res;
    assign w_load  = i_job_valid && (!r_out_valid || i_pop);

    // beat contents for the current sequencer step
    always_comb begin
        w_res              = '0;
        w_res.event_temp   = i_job.temp;
        w_res.level        = i_job.level;
        w_res.panic_on     = i_job.panic_on;
        w_res.sensor_ok    = i_job.sensor_ok;
        w_res.sample_count = i_job.count;
        if (i_job.fault) begin
            w_res.event_kind = KIND_FAULT;
            w_res.last       = 1'b1;
        end else begin
            unique case (r_beat)
                BEAT_UPD: begin
                    w_res.event_kind = KIND_UPDATE;
                    w_res.last       = !i_job.lvl_evt && !i_job.pnc_evt;
                end
                BEAT_LVL: begin
                    w_res.event_kind = (i_job.lvl_kind == LVL_CRIT) ? KIND_CRIT
                                                                   : KIND_WARN;
                    w_res.last       = !i_job.pnc_evt;
                end
                default: begin
                    w_res.event_kind = KIND_PANIC;
                    w_res.last       = 1'b1;
                end
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_beat = r_beat;
        if (w_load) begin
            if (w_res.last) begin
                n_beat = BEAT_UPD;
            end else begin
                unique case (r_beat)
                    BEAT_UPD: n_beat = i_job.lvl_evt ? BEAT_LVL : BEAT_PNC;
                    default:  n_beat = BEAT_PNC;
                endcase
            end
        end
    end

    // job retires with its last beat
    always_comb begin
        o_job_pop = w_load && w_res.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat      <= BEAT_UPD;
            r_out_valid <= 1'b0;
        end else begin
            r_beat <= n_beat;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= w_res;
        end
    end

endmodule

@@ rtl/thermal_level_monitor_unit.sv @@
// ============================================================================
// thermal_level_monitor_unit: threshold monitor with hysteresis and panic latch
// Throughput: one item per cycle in while the job queue has room; one result
// beat per cycle out while popped (1-3 per sample, set by the back-end
// sequencer). The queue absorbs bursts; beats load an output register.
// Reset: synchronous; clears state, loads register defaults and grace window.
// ============================================================================
`timescale 1ns / 1ps

module thermal_level_monitor_unit
    import tlm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_cmd                 i_item,
    output logic                 o_full,
    output logic                 o_empty,
    output t_res                 o_res,
    input  logic                 i_pop,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    logic w_job_push, w_job_full, w_job_valid, w_job_pop;
    t_job w_job_in, w_job_out;

    // sample classification and monitor state
    tlm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_job_push  (w_job_push),
        .o_job       (w_job_in),
        .i_job_full  (w_job_full)
    );

    // decoupling queue
    tlm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (w_job_full),
        .o_valid (w_job_valid),
        .o_job   (w_job_out),
        .i_pop   (w_job_pop)
    );

    // result beat expansion
    tlm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .o_empty     (o_empty),
        .o_res       (o_res),
        .i_pop       (i_pop)
    );

endmodule

@@ rtl/tlm_checker.sv @@
// ============================================================================
// tlm_checker: port-level checks of the thermal level monitor
// Watches the result side and reset behavior; bound to the top level.
// ============================================================================
`timescale 1ns / 1ps

module tlm_checker
    import tlm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_empty,
    input t_res o_res,
    input logic i_pop
);

    // reset drains the result side
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result side not empty after reset");

    // a waiting beat holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_res)))
        else $error("waiting result beat changed");

    // a fault beat stands alone and reports an unhealthy sensor
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_res.event_kind == KIND_FAULT))
            |-> (o_res.last && !o_res.sensor_ok))
        else $error("bad fault beat");

    // a panic beat ends its group and shows the latch set
    a_panic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_res.event_kind == KIND_PANIC))
            |-> (o_res.last && o_res.panic_on && o_res.sensor_ok))
        else $error("bad panic beat");

    // beats after a non-final beat belong to the same sample
    a_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_res.last) |=>
            (!o_empty && (o_res.sample_count == $past(o_res.sample_count))
             && (o_res.event_kind != KIND_UPDATE)))
        else $error("result group broken");

endmodule

bind thermal_level_monitor_unit tlm_checker u_tlm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_empty (o_empty),
    .o_res   (o_res),
    .i_pop   (i_pop)
);
